// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL files. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define UBO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define UBO_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error(msg);

`else

`define UBO_ASSERT(lbl, clk, rst_n, prop, msg)
`define UBO_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg)

`endif

`endif

// ===== hdl/ubo_pkg.sv =====
// ----------------------------------------------------------------------------
// ubo_pkg
// Types, constants and type tables of the uniform block offset allocator.
// ----------------------------------------------------------------------------
package ubo_pkg;

    localparam int OFFSET_BITS_DEF      = 16;
    localparam int ARRAY_COUNT_BITS_DEF = 10;
    localparam int ARRAY_COUNT_BITS_MAX = 16;
    localparam int FIELD_BITS           = 16;
    localparam int TYPE_BITS            = 4;
    localparam int CFG_BITS             = 16;
    localparam int SIZE_BITS            = 7;
    localparam int AMT_BITS             = ARRAY_COUNT_BITS_MAX + SIZE_BITS;
    localparam int TYPE_COUNT           = 12;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [CFG_BITS-1:0] MAX_PUSH_RESET = 16'd128;

    typedef logic [3:0]           t_mask;
    typedef logic [SIZE_BITS-1:0] t_size;
    typedef logic [TYPE_BITS-1:0] t_type_code;

    // Request kinds on the input channel.
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Type codes that get special std140 handling.
    localparam t_type_code TYPE_HALF2X2  = 4'd8;
    localparam t_type_code TYPE_FLOAT2X2 = 4'd9;

    localparam t_mask STD140_ARRAY_MASK = 4'hF;
    localparam t_mask FLIP_MASK         = 4'h7;
    localparam t_size MAT2_STD140_SIZE  = 7'd32;
    localparam t_size MIN_ARRAY_STRIDE  = 7'd16;
    localparam t_size FLIP_PAD          = 7'd8;

    // Alignment mask and packed size per valid type code.
    localparam t_mask ALIGN_MASK_TAB [TYPE_COUNT] = '{
        4'h1, 4'h3, 4'h7, 4'h7, 4'h3, 4'h7, 4'hF, 4'hF, 4'h7, 4'h7, 4'hF, 4'hF
    };
    localparam t_size SIZE_TAB [TYPE_COUNT] = '{
        7'd2, 7'd4, 7'd6, 7'd8, 7'd4, 7'd8, 7'd12, 7'd16, 7'd16, 7'd16, 7'd48, 7'd64
    };

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_CLEAR,
        CMD_BAD_TYPE
    } t_cmd_kind;

    // Classified request as it travels from the front end to the back end.
    typedef struct packed {
        t_cmd_kind            kind;
        t_mask                mask140;
        t_mask                mask430;
        logic [AMT_BITS-1:0]  amt140;
        logic [AMT_BITS-1:0]  amt430;
    } t_cmd;

endpackage

// ===== hdl/ubo_if.sv =====
// ----------------------------------------------------------------------------
// ubo_if
// Valid/ready channels for requests and results of the offset allocator.
// ----------------------------------------------------------------------------
interface ubo_req_if #(
    parameter int ARRAY_COUNT_BITS = ubo_pkg::ARRAY_COUNT_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic [ubo_pkg::TYPE_BITS-1:0]      type_code;
    logic [ARRAY_COUNT_BITS-1:0]        array_count;

    modport source (output valid, req_type, type_code, array_count, input ready);
    modport sink   (input valid, req_type, type_code, array_count, output ready);
endinterface

interface ubo_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ubo_pkg::FIELD_BITS-1:0]     offset_std140;
    logic [ubo_pkg::FIELD_BITS-1:0]     offset_std430;
    logic [ubo_pkg::FIELD_BITS-1:0]     end_std140;
    logic [ubo_pkg::FIELD_BITS-1:0]     end_std430;
    logic                               use_push_constants;
    logic [ubo_pkg::FIELD_BITS-1:0]     flip_offset;
    logic                               type_error;
    logic                               overflow;

    modport source (
        output valid, offset_std140, offset_std430, end_std140, end_std430,
               use_push_constants, flip_offset, type_error, overflow,
        input  ready
    );
    modport sink (
        input  valid, offset_std140, offset_std430, end_std140, end_std430,
               use_push_constants, flip_offset, type_error, overflow,
        output ready
    );
endinterface

// ===== hdl/ubo_front.sv =====
// ----------------------------------------------------------------------------
// ubo_front
// Classifies a request and works out the per-layout alignment mask and the
// byte amount it advances each layout by.
// ----------------------------------------------------------------------------
module ubo_front #(
    parameter int ARRAY_COUNT_BITS = ubo_pkg::ARRAY_COUNT_BITS_DEF
) (
    ubo_req_if.sink         i_req,
    input  logic            i_queue_ready,
    output logic            o_push,
    output ubo_pkg::t_cmd   o_cmd
);

    logic                           type_ok;
    logic                           is_array;
    ubo_pkg::t_type_code            code;
    logic [$clog2(ubo_pkg::TYPE_COUNT)-1:0] idx;
    logic [ARRAY_COUNT_BITS-1:0]    count;
    ubo_pkg::t_mask                 mask;
    ubo_pkg::t_size                 size430;
    ubo_pkg::t_size                 size140;
    ubo_pkg::t_size                 elem430;
    ubo_pkg::t_size                 elem140;

    assign code     = i_req.type_code;
    assign count    = i_req.array_count;
    assign type_ok  = code < ubo_pkg::TYPE_BITS'(ubo_pkg::TYPE_COUNT);
    assign idx      = type_ok ? code[$clog2(ubo_pkg::TYPE_COUNT)-1:0] : '0;
    assign is_array = |count;

    always_comb begin
        mask    = ubo_pkg::ALIGN_MASK_TAB[idx];
        size430 = ubo_pkg::SIZE_TAB[idx];
        // A 2x2 matrix keeps two 16-byte columns under std140.
        size140 = (code == ubo_pkg::TYPE_HALF2X2 || code == ubo_pkg::TYPE_FLOAT2X2)
                  ? ubo_pkg::MAT2_STD140_SIZE : size430;
        elem430 = (size430 < ubo_pkg::MIN_ARRAY_STRIDE) ? ubo_pkg::MIN_ARRAY_STRIDE : size430;
        elem140 = (size140 < ubo_pkg::MIN_ARRAY_STRIDE) ? ubo_pkg::MIN_ARRAY_STRIDE : size140;

        o_cmd.mask430 = mask;
        o_cmd.mask140 = (is_array || code == ubo_pkg::TYPE_FLOAT2X2)
                        ? ubo_pkg::STD140_ARRAY_MASK : mask;
        o_cmd.amt430  = is_array
                        ? ubo_pkg::AMT_BITS'(elem430) * ubo_pkg::AMT_BITS'(count)
                        : ubo_pkg::AMT_BITS'(size430);
        o_cmd.amt140  = is_array
                        ? ubo_pkg::AMT_BITS'(elem140) * ubo_pkg::AMT_BITS'(count)
                        : ubo_pkg::AMT_BITS'(size140);

        if (i_req.req_type == ubo_pkg::REQ_CLEAR) begin
            o_cmd.kind = ubo_pkg::CMD_CLEAR;
        end else if (!type_ok) begin
            o_cmd.kind = ubo_pkg::CMD_BAD_TYPE;
        end else begin
            o_cmd.kind = ubo_pkg::CMD_ADD;
        end
    end

    assign i_req.ready = i_queue_ready;
    assign o_push      = i_req.valid && i_queue_ready;

endmodule

// ===== hdl/ubo_queue.sv =====
// ----------------------------------------------------------------------------
// ubo_queue
// Short first-in first-out queue of classified requests between the front
// end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ubo_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ubo_pkg::t_cmd   i_cmd,
    output logic            o_ready,
    output logic            o_valid,
    output ubo_pkg::t_cmd   o_cmd,
    input  logic            i_pop
);

    localparam int PTR_BITS = (ubo_pkg::QUEUE_DEPTH > 1) ? $clog2(ubo_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(ubo_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(ubo_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(ubo_pkg::QUEUE_DEPTH);

    ubo_pkg::t_cmd          r_mem [ubo_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    r_wr_ptr;
    logic [PTR_BITS-1:0]    r_rd_ptr;
    logic [CNT_BITS-1:0]    r_count;
    logic [PTR_BITS-1:0]    n_wr_ptr;
    logic [PTR_BITS-1:0]    n_rd_ptr;
    logic [CNT_BITS-1:0]    n_count;

    assign o_ready = r_count != FULL_CNT;
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `UBO_ASSERT(a_queue_count_bounded, i_clk, i_rst_n, r_count <= FULL_CNT, "queue count past depth")
    `UBO_ASSERT(a_queue_no_push_full, i_clk, i_rst_n, !(i_push && r_count == FULL_CNT), "push into a full queue")
    `UBO_ASSERT(a_queue_no_pop_empty, i_clk, i_rst_n, !(i_pop && r_count == '0), "pop from an empty queue")

endmodule

// ===== hdl/ubo_back.sv =====
// ----------------------------------------------------------------------------
// ubo_back
// Holds the running std140 and std430 ends, places each request and forms
// the result item in an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ubo_back #(
    parameter int OFFSET_BITS = ubo_pkg::OFFSET_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ubo_pkg::CFG_BITS-1:0]    i_max_push,
    input  logic                            i_valid,
    input  ubo_pkg::t_cmd                   i_cmd,
    output logic                            o_pop,
    ubo_rsp_if.source                       o_rsp
);

    localparam int SUM_BITS  = ((OFFSET_BITS > ubo_pkg::AMT_BITS) ? OFFSET_BITS
                                                                  : ubo_pkg::AMT_BITS) + 2;
    localparam int WIDE_BITS = (OFFSET_BITS > ubo_pkg::FIELD_BITS) ? OFFSET_BITS
                                                                   : ubo_pkg::FIELD_BITS;
    localparam int CMP_BITS  = WIDE_BITS + 1;
    localparam int FB        = ubo_pkg::FIELD_BITS;

    logic [OFFSET_BITS-1:0]     r_end140;
    logic [OFFSET_BITS-1:0]     r_end430;
    logic [OFFSET_BITS-1:0]     n_end140;
    logic [OFFSET_BITS-1:0]     n_end430;

    logic                       r_s1_valid;
    logic [FB-1:0]              r_s1_off140;
    logic [FB-1:0]              r_s1_off430;
    logic                       r_s1_terr;
    logic                       r_s1_ovf;

    logic                       r_s2_valid;
    logic [FB-1:0]              r_s2_off140;
    logic [FB-1:0]              r_s2_off430;
    logic [FB-1:0]              r_s2_end140;
    logic [FB-1:0]              r_s2_end430;
    logic                       r_s2_push;
    logic [FB-1:0]              r_s2_flip;
    logic                       r_s2_terr;
    logic                       r_s2_ovf;

    logic                       s1_load;
    logic                       s2_load;
    logic [OFFSET_BITS:0]       off140;
    logic [OFFSET_BITS:0]       off430;
    logic [SUM_BITS-1:0]        new140;
    logic [SUM_BITS-1:0]        new430;
    logic                       ovf;
    logic                       placed;
    logic [WIDE_BITS-1:0]       wide_off140;
    logic [WIDE_BITS-1:0]       wide_off430;

    logic                       push_ok;
    logic [OFFSET_BITS-1:0]     chosen;
    logic [OFFSET_BITS:0]       flip_sum;
    logic [OFFSET_BITS-1:0]     flip;
    logic [WIDE_BITS-1:0]       wide_end140;
    logic [WIDE_BITS-1:0]       wide_end430;
    logic [WIDE_BITS-1:0]       wide_flip;

    // Stage control: output register, then placement stage, then queue pop.
    assign s2_load = !r_s2_valid || o_rsp.ready;
    assign s1_load = !r_s1_valid || s2_load;
    assign o_pop   = i_valid && s1_load;

    // Placement: align each running end, then advance it.
    always_comb begin
        off140 = ((OFFSET_BITS+1)'(r_end140) + (OFFSET_BITS+1)'(i_cmd.mask140))
                 & ~(OFFSET_BITS+1)'(i_cmd.mask140);
        off430 = ((OFFSET_BITS+1)'(r_end430) + (OFFSET_BITS+1)'(i_cmd.mask430))
                 & ~(OFFSET_BITS+1)'(i_cmd.mask430);
        new140 = SUM_BITS'(off140) + SUM_BITS'(i_cmd.amt140);
        new430 = SUM_BITS'(off430) + SUM_BITS'(i_cmd.amt430);
        ovf    = (|new140[SUM_BITS-1:OFFSET_BITS]) || (|new430[SUM_BITS-1:OFFSET_BITS]);
        placed = (i_cmd.kind == ubo_pkg::CMD_ADD) && !ovf;

        wide_off140 = WIDE_BITS'(off140[OFFSET_BITS-1:0]);
        wide_off430 = WIDE_BITS'(off430[OFFSET_BITS-1:0]);

        n_end140 = r_end140;
        n_end430 = r_end430;
        if (o_pop) begin
            if (i_cmd.kind == ubo_pkg::CMD_CLEAR) begin
                n_end140 = '0;
                n_end430 = '0;
            end else if (placed) begin
                n_end140 = new140[OFFSET_BITS-1:0];
                n_end430 = new430[OFFSET_BITS-1:0];
            end
        end
    end

    // Finish: push constant decision and flip offset from the updated ends.
    always_comb begin
        push_ok  = (r_end430 != '0)
                   && (CMP_BITS'(r_end430) + CMP_BITS'(ubo_pkg::FLIP_PAD)
                       <= CMP_BITS'(i_max_push));
        chosen   = push_ok ? r_end430 : r_end140;
        flip_sum = ((OFFSET_BITS+1)'(chosen) + (OFFSET_BITS+1)'(ubo_pkg::FLIP_MASK))
                   & ~(OFFSET_BITS+1)'(ubo_pkg::FLIP_MASK);
        flip     = flip_sum[OFFSET_BITS-1:0];

        wide_end140 = WIDE_BITS'(r_end140);
        wide_end430 = WIDE_BITS'(r_end430);
        wide_flip   = WIDE_BITS'(flip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end140   <= '0;
            r_end430   <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_end140 <= n_end140;
            r_end430 <= n_end430;
            if (s1_load) begin
                r_s1_valid <= i_valid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_off140 <= placed ? wide_off140[FB-1:0] : '0;
            r_s1_off430 <= placed ? wide_off430[FB-1:0] : '0;
            r_s1_terr   <= i_cmd.kind == ubo_pkg::CMD_BAD_TYPE;
            r_s1_ovf    <= (i_cmd.kind == ubo_pkg::CMD_ADD) && ovf;
        end
        if (s2_load) begin
            r_s2_off140 <= r_s1_off140;
            r_s2_off430 <= r_s1_off430;
            r_s2_end140 <= wide_end140[FB-1:0];
            r_s2_end430 <= wide_end430[FB-1:0];
            r_s2_push   <= push_ok;
            r_s2_flip   <= wide_flip[FB-1:0];
            r_s2_terr   <= r_s1_terr;
            r_s2_ovf    <= r_s1_ovf;
        end
    end

    assign o_rsp.valid              = r_s2_valid;
    assign o_rsp.offset_std140      = r_s2_off140;
    assign o_rsp.offset_std430      = r_s2_off430;
    assign o_rsp.end_std140         = r_s2_end140;
    assign o_rsp.end_std430         = r_s2_end430;
    assign o_rsp.use_push_constants = r_s2_push;
    assign o_rsp.flip_offset        = r_s2_flip;
    assign o_rsp.type_error         = r_s2_terr;
    assign o_rsp.overflow           = r_s2_ovf;

    `UBO_ASSERT_NEXT(a_clear_zeroes_ends, i_clk, i_rst_n, o_pop && i_cmd.kind == ubo_pkg::CMD_CLEAR, r_end140 == '0 && r_end430 == '0, "clear left a running end nonzero")
    `UBO_ASSERT_NEXT(a_bad_type_holds_ends, i_clk, i_rst_n, o_pop && i_cmd.kind == ubo_pkg::CMD_BAD_TYPE, $stable(r_end140) && $stable(r_end430), "invalid type moved a running end")
    `UBO_ASSERT(a_flags_exclusive, i_clk, i_rst_n, r_s1_valid |-> !(r_s1_terr && r_s1_ovf), "type error and overflow both set")

endmodule

// ===== hdl/uniform_block_offset_allocator_top.sv =====
// ----------------------------------------------------------------------------
// uniform_block_offset_allocator_top
// A request item goes through the queue, placement and output registers.
// Throughput: one item per cycle unless stalled (running-end update bound).
// Reset (synchronous, active low): ends zero, limit 128, pipeline empty.
// ----------------------------------------------------------------------------
module uniform_block_offset_allocator_top #(
    parameter int OFFSET_BITS      = ubo_pkg::OFFSET_BITS_DEF,
    parameter int ARRAY_COUNT_BITS = ubo_pkg::ARRAY_COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ubo_req_if.sink                         i_req,
    ubo_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [ubo_pkg::CFG_BITS-1:0]    i_cfg_wdata
);

    // The block is split into a front end that decodes the type code into
    // alignment masks and advance amounts (including the array multiply),
    // and a back end that owns the two running ends. A two-entry queue sits
    // between them so either side can stall without holding up the other.

    logic [ubo_pkg::CFG_BITS-1:0]   r_max_push;
    logic                           front_push;
    ubo_pkg::t_cmd                  front_cmd;
    logic                           queue_ready;
    logic                           queue_valid;
    ubo_pkg::t_cmd                  queue_cmd;
    logic                           back_pop;

    // Push constant size limit. The user must write it only while no item is in
    // flight (the block does not enforce this), so the back end reads it directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_push <= ubo_pkg::MAX_PUSH_RESET;
        end else if (i_cfg_we) begin
            r_max_push <= i_cfg_wdata;
        end
    end

    // Front end: accepts an item whenever the queue has room.
    ubo_front #(
        .ARRAY_COUNT_BITS (ARRAY_COUNT_BITS)
    ) u_front (
        .i_req         (i_req),
        .i_queue_ready (queue_ready),
        .o_push        (front_push),
        .o_cmd         (front_cmd)
    );

    ubo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd),
        .i_pop   (back_pop)
    );

    // Back end: places one request per cycle, unless the result channel stalls,
    // against the running ends, then forms the push constant decision and flip
    // offset in the output register that drives the result channel.
    ubo_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_max_push (r_max_push),
        .i_valid    (queue_valid),
        .i_cmd      (queue_cmd),
        .o_pop      (back_pop),
        .o_rsp      (o_rsp)
    );

endmodule
